### hw/rtl/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg: shared types and constants for the port lock arbiter
// Field widths, request and state codes, sequencer states, queue operations
// and the control bundle for the port store.
// ----------------------------------------------------------------------------
package pla_pkg;

  // fixed field widths on the streams
  localparam int CH_W        = 4;
  localparam int PMASK_W     = 32;
  localparam int RMASK_W     = 16;
  localparam int WCNT_W      = 5;
  localparam int CST_W       = 2;
  localparam int IN_TDATA_W  = 40;  // channel_index + port_mask, padded to bytes
  localparam int OUT_TDATA_W = 24;  // granted + caller_state + running_mask + waiting_count

  // request kind (in_tuser)
  localparam logic MODE_LOCK   = 1'b0;
  localparam logic MODE_UNLOCK = 1'b1;

  // caller state codes
  localparam logic [CST_W-1:0] CST_IDLE = 2'd0;
  localparam logic [CST_W-1:0] CST_WAIT = 2'd1;
  localparam logic [CST_W-1:0] CST_RUN  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REBUILD,
    S_PRIME,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_PUSH,
    Q_KEEP,
    Q_DROP
  } q_op_t;

  typedef struct packed {
    logic wr;           // write new port mask for the caller
    logic busy_clr;     // clear busy mask (start of rebuild)
    logic busy_or_new;  // OR new port mask into busy
    logic busy_or_rd;   // OR read-back port mask into busy
  } pst_ctl_t;

endpackage

### hw/rtl/pla_wait_queue.sv
// ----------------------------------------------------------------------------
// pla_wait_queue: FIFO of waiting channels
// Shift-register queue. Push appends at the tail; a scan step pops the head
// and either drops it or re-appends it at the tail, so one full pass keeps
// the order of the entries that stay.
// ----------------------------------------------------------------------------
module pla_wait_queue #(
  parameter int NUM_CHANNELS = 16,
  parameter int CH_IDX_W     = 4,
  parameter int LEN_W        = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pla_pkg::q_op_t      op,
  input  logic [CH_IDX_W-1:0] push_id,
  output logic [CH_IDX_W-1:0] head,
  output logic [CH_IDX_W-1:0] next_head,
  output logic [LEN_W-1:0]    len
);
  import pla_pkg::*;

  logic [CH_IDX_W-1:0] q_r   [NUM_CHANNELS];
  logic [CH_IDX_W-1:0] q_nxt [NUM_CHANNELS];
  logic [LEN_W-1:0]    len_r, len_nxt, len_m1;

  assign head      = q_r[0];
  assign next_head = (len_r > LEN_W'(1)) ? q_r[1] : q_r[0];
  assign len       = len_r;
  assign len_m1    = len_r - LEN_W'(1);

  always_comb begin
    q_nxt   = q_r;
    len_nxt = len_r;
    case (op)
      Q_PUSH: begin
        for (int j = 0; j < NUM_CHANNELS; j++) begin
          if (LEN_W'(j) == len_r) q_nxt[j] = push_id;
        end
        len_nxt = len_r + LEN_W'(1);
      end
      Q_KEEP, Q_DROP: begin
        for (int j = 0; j < NUM_CHANNELS - 1; j++) begin
          q_nxt[j] = q_r[j+1];
        end
        if (op == Q_KEEP) begin
          for (int j = 0; j < NUM_CHANNELS; j++) begin
            if (LEN_W'(j) == len_m1) q_nxt[j] = q_r[0];
          end
        end else begin
          len_nxt = len_m1;
        end
      end
      default: begin
        q_nxt   = q_r;
        len_nxt = len_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

endmodule

### hw/rtl/pla_port_store.sv
// ----------------------------------------------------------------------------
// pla_port_store: per-channel port masks and the busy-port mask
// One-write, one-read memory of port masks with registered read, the busy
// register, and the two conflict checks against it (new mask and read-back mask).
// ----------------------------------------------------------------------------
module pla_port_store #(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_PORTS    = 32,
  parameter int CH_IDX_W     = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pla_pkg::pst_ctl_t    ctl,
  input  logic [CH_IDX_W-1:0]  wr_addr,
  input  logic [CH_IDX_W-1:0]  rd_addr,
  input  logic [NUM_PORTS-1:0] new_ports,
  output logic                 new_conflict,
  output logic                 rd_conflict
);
  import pla_pkg::*;

  logic [NUM_PORTS-1:0] mem_r [NUM_CHANNELS];
  logic [NUM_PORTS-1:0] rd_ports_r;
  logic [NUM_PORTS-1:0] busy_r, busy_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr) mem_r[wr_addr] <= new_ports;
    rd_ports_r <= mem_r[rd_addr];
  end

  assign new_conflict = |(new_ports & busy_r);
  assign rd_conflict  = |(rd_ports_r & busy_r);

  always_comb begin
    if (ctl.busy_clr) begin
      busy_nxt = '0;
    end else begin
      busy_nxt = busy_r
               | (ctl.busy_or_new ? new_ports : '0)
               | (ctl.busy_or_rd ? rd_ports_r : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule

### hw/rtl/port_lock_fifo_arbiter_core.sv
// ----------------------------------------------------------------------------
// port_lock_fifo_arbiter_core: port lock manager with FIFO wait queue
// Channels lock sets of shared ports; conflicting lockers wait in arrival
// order and are promoted when the ports they need come free.
// ----------------------------------------------------------------------------
// Lock, or unlock of an idle channel: EXEC, then DONE, then the result.
// Unlock of a waiting channel: EXEC, PRIME, SCAN, DONE; the queue scan checks
// one waiter a cycle over W waiters, W = queue length before unlock. Unlock of
// a running channel adds REBUILD before PRIME (busy mask rebuild reads every stored port mask).
// One request in flight; in_tready is high only while idle.
// Reset (rst_n low, synchronous): all channels idle, queue empty, no result.
// ----------------------------------------------------------------------------
module port_lock_fifo_arbiter_core #(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_PORTS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pla_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] channel_index, [35:4] port_mask
  input  logic                             in_tuser,   // [0] mode (0 lock, 1 unlock)
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pla_pkg::OUT_TDATA_W-1:0]  out_tdata   // [0] granted, [2:1] caller_state,
                                                       // [18:3] running_mask,
                                                       // [23:19] waiting_count
);
  import pla_pkg::*;

  localparam int CH_IDX_W = $clog2(NUM_CHANNELS);
  localparam int LEN_W    = $clog2(NUM_CHANNELS + 1);

  // sequencer
  state_t state_r, state_nxt;

  // captured request
  logic                 req_unlock_r, req_unlock_nxt;
  logic [CH_W-1:0]      req_ch_r, req_ch_nxt;
  logic [NUM_PORTS-1:0] req_ports_r, req_ports_nxt;

  // per-channel status
  logic [NUM_CHANNELS-1:0] run_r, run_nxt;
  logic [NUM_CHANNELS-1:0] wait_r, wait_nxt;

  // rebuild / scan bookkeeping
  logic [CH_IDX_W-1:0] cnt_r, cnt_nxt;    // rebuild read pointer
  logic [LEN_W-1:0]    rem_r, rem_nxt;    // waiters left to check
  logic                pend_r, pend_nxt;  // rebuild read in flight belongs to a runner

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // submodule links
  q_op_t                q_op;
  logic [CH_IDX_W-1:0]  q_head, q_next_head;
  logic [LEN_W-1:0]     q_len;
  pst_ctl_t             pst_ctl;
  logic [CH_IDX_W-1:0]  rd_addr;
  logic                 new_conflict, rd_conflict;

  // request decode
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                res_granted;
  logic [CST_W-1:0]    res_cstate;
  logic [RMASK_W-1:0]  res_rmask;
  logic [WCNT_W-1:0]   res_wcnt;

  assign ch_ok  = int'(req_ch_r) < NUM_CHANNELS;
  assign ch_idx = CH_IDX_W'(req_ch_r);

  // port masks wider than NUM_PORTS are cut, narrower ones zero-extended
  assign req_ports_nxt = (state_r == S_IDLE) ? NUM_PORTS'(in_tdata[CH_W +: PMASK_W])
                                             : req_ports_r;

  pla_wait_queue #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CH_IDX_W     (CH_IDX_W),
    .LEN_W        (LEN_W)
  ) u_wait_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (q_op),
    .push_id   (ch_idx),
    .head      (q_head),
    .next_head (q_next_head),
    .len       (q_len)
  );

  pla_port_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_PORTS    (NUM_PORTS),
    .CH_IDX_W     (CH_IDX_W)
  ) u_port_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (pst_ctl),
    .wr_addr      (ch_idx),
    .rd_addr      (rd_addr),
    .new_ports    (req_ports_r),
    .new_conflict (new_conflict),
    .rd_conflict  (rd_conflict)
  );

  // result fields; running_mask only shows channels 0..15
  for (genvar c = 0; c < RMASK_W; c++) begin : g_rmask
    if (c < NUM_CHANNELS) begin : g_on
      assign res_rmask[c] = run_r[c];
    end else begin : g_off
      assign res_rmask[c] = 1'b0;
    end
  end

  assign res_granted = ch_ok && (req_unlock_r == MODE_LOCK) && run_r[ch_idx];
  assign res_wcnt    = WCNT_W'(q_len);

  always_comb begin
    if (!ch_ok) begin
      res_cstate = CST_IDLE;
    end else if (run_r[ch_idx]) begin
      res_cstate = CST_RUN;
    end else if (wait_r[ch_idx]) begin
      res_cstate = CST_WAIT;
    end else begin
      res_cstate = CST_IDLE;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    req_unlock_nxt = req_unlock_r;
    req_ch_nxt     = req_ch_r;
    run_nxt        = run_r;
    wait_nxt       = wait_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    pend_nxt       = pend_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    q_op           = Q_NONE;
    pst_ctl        = '0;
    rd_addr        = q_head;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_unlock_nxt = in_tuser;
          req_ch_nxt     = in_tdata[CH_W-1:0];
          state_nxt      = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        if (ch_ok) begin
          if (req_unlock_r == MODE_LOCK) begin
            // lock from idle: record ports, then run or queue
            if (!run_r[ch_idx] && !wait_r[ch_idx]) begin
              pst_ctl.wr = 1'b1;
              if (new_conflict && (q_len < LEN_W'(NUM_CHANNELS))) begin
                q_op             = Q_PUSH;
                wait_nxt[ch_idx] = 1'b1;
              end else begin
                run_nxt[ch_idx]     = 1'b1;
                pst_ctl.busy_or_new = 1'b1;
              end
            end
          end else if (wait_r[ch_idx]) begin
            // caller leaves the queue during the scan pass
            wait_nxt[ch_idx] = 1'b0;
            rem_nxt          = q_len;
            pend_nxt         = 1'b0;
            state_nxt        = S_PRIME;
          end else if (run_r[ch_idx]) begin
            run_nxt[ch_idx]  = 1'b0;
            pst_ctl.busy_clr = 1'b1;
            cnt_nxt          = '0;
            pend_nxt         = 1'b0;
            rem_nxt          = q_len;
            state_nxt        = S_REBUILD;
          end
        end
      end

      S_REBUILD: begin
        // one stored mask read per cycle, ORed into busy in the cycle after
        rd_addr            = cnt_r;
        pst_ctl.busy_or_rd = pend_r;
        pend_nxt           = run_r[cnt_r];
        cnt_nxt            = cnt_r + CH_IDX_W'(1);
        if (cnt_r == CH_IDX_W'(NUM_CHANNELS - 1)) state_nxt = S_PRIME;
      end

      S_PRIME: begin
        // finish last rebuild read, fetch head's ports
        pst_ctl.busy_or_rd = pend_r;
        rd_addr            = q_head;
        state_nxt          = (rem_r == '0) ? S_DONE : S_SCAN;
      end

      S_SCAN: begin
        rd_addr = q_next_head;
        rem_nxt = rem_r - LEN_W'(1);
        if (q_head == ch_idx) begin
          q_op = Q_DROP;
        end else if (!rd_conflict) begin
          q_op               = Q_DROP;
          run_nxt[q_head]    = 1'b1;
          wait_nxt[q_head]   = 1'b0;
          pst_ctl.busy_or_rd = 1'b1;
        end else begin
          q_op = Q_KEEP;
        end
        if (rem_r == LEN_W'(1)) state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_wcnt, res_rmask, res_cstate, res_granted};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= '0;
      wait_r      <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      wait_r      <= wait_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_unlock_r <= req_unlock_nxt;
    req_ch_r     <= req_ch_nxt;
    req_ports_r  <= req_ports_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

### hw/rtl/pla_checker.sv
// ----------------------------------------------------------------------------
// pla_checker: port-level checks for the port lock arbiter
// Watches the request and result streams of the top level; bound below.
// ----------------------------------------------------------------------------
module pla_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pla_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import pla_pkg::*;

  logic             res_granted;
  logic [CST_W-1:0] res_cstate;

  assign res_granted = out_tdata[0];
  assign res_cstate  = out_tdata[CST_W:1];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a grant always reports the caller as running
  a_grant_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_granted |-> res_cstate == CST_RUN)
    else $error("granted without running state");

  // caller state is a defined code
  a_cstate_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_cstate == CST_IDLE || res_cstate == CST_WAIT ||
                    res_cstate == CST_RUN))
    else $error("undefined caller state");

  // one request at a time
  a_single_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind port_lock_fifo_arbiter_core pla_checker u_pla_checker (.*);

### dv/tb_port_lock_fifo_arbiter_core.sv
// ----------------------------------------------------------------------------
// tb_port_lock_fifo_arbiter_core: self-checking bench for the port lock arbiter
// Lock and unlock requests go in on the request stream, and a status word comes
// back for each one. A lock table model inside the bench predicts every status
// word. Each word that comes back is compared field by field, in order. The
// request side sends in bursts with gaps, and the result side stalls on its own
// changing pattern.
// ----------------------------------------------------------------------------
module tb_port_lock_fifo_arbiter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pla_pkg::*;

  localparam int N_CH    = 16;
  localparam int N_PORTS = 32;
  localparam int N_RANDOM = 1900;

  // one lock/unlock request as the driver sees it
  typedef struct {
    logic               mode;
    logic [CH_W-1:0]    ch;
    logic [PMASK_W-1:0] ports;
  } lock_req_t;

  // status word returned for each request
  typedef struct {
    logic               granted;
    logic [CST_W-1:0]   cstate;
    logic [RMASK_W-1:0] run_mask;
    logic [WCNT_W-1:0]  wait_cnt;
  } lock_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = MODE_LOCK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  port_lock_fifo_arbiter_core #(
    .NUM_CHANNELS(N_CH),
    .NUM_PORTS   (N_PORTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Lock table model: per-channel state, stored port masks, busy ports, and
  // the FIFO of waiting channels.
  // --------------------------------------------------------------------------
  logic [CST_W-1:0]   lk_state [N_CH];
  logic [PMASK_W-1:0] lk_ports [N_CH];
  logic [PMASK_W-1:0] lk_busy;
  logic [CH_W-1:0]    wait_line[$];

  lock_req_t    pending_reqs[$];
  lock_status_t expected_status[$];
  int           err_count = 0;

  // Head-to-tail scan. Every waiter whose ports are clear of the busy set runs.
  // The busy set grows as the scan goes, so later waiters see the earlier
  // promotions.
  function automatic void promote_free_waiters();
    int          i;
    logic [CH_W-1:0] c;
    i = 0;
    while (i < wait_line.size()) begin
      c = wait_line[i];
      if ((lk_ports[c] & lk_busy) == '0) begin
        wait_line.delete(i);
        lk_state[c] = CST_RUN;
        lk_busy |= lk_ports[c];
      end else begin
        i++;
      end
    end
  endfunction

  function automatic lock_status_t arbitrate_request(lock_req_t r);
    lock_status_t s;
    logic [PMASK_W-1:0] acc;
    s.granted = 1'b0;
    if (r.mode == MODE_LOCK) begin
      // only a lock from idle does anything; repeats just report the state
      if (lk_state[r.ch] == CST_IDLE) begin
        lk_ports[r.ch] = r.ports;
        if ((r.ports & lk_busy) != '0 && wait_line.size() < N_CH) begin
          wait_line.push_back(r.ch);
          lk_state[r.ch] = CST_WAIT;
        end else begin
          lk_state[r.ch] = CST_RUN;
          lk_busy |= r.ports;
        end
      end
      s.granted = (lk_state[r.ch] == CST_RUN);
    end else if (lk_state[r.ch] == CST_WAIT) begin
      for (int i = 0; i < wait_line.size(); i++) begin
        if (wait_line[i] == r.ch) begin
          wait_line.delete(i);
          break;
        end
      end
      lk_state[r.ch] = CST_IDLE;
      promote_free_waiters();
    end else if (lk_state[r.ch] == CST_RUN) begin
      lk_state[r.ch] = CST_IDLE;
      acc = '0;
      for (int c = 0; c < N_CH; c++)
        if (lk_state[c] == CST_RUN) acc |= lk_ports[c];
      lk_busy = acc;
      promote_free_waiters();
    end
    // an unlock of an idle channel leaves everything alone, with no scan
    s.cstate = lk_state[r.ch];
    for (int c = 0; c < N_CH; c++)
      s.run_mask[c] = (lk_state[c] == CST_RUN);
    s.wait_cnt = WCNT_W'(wait_line.size());
    return s;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $time, field, got, want);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_req(logic mode, int ch, logic [PMASK_W-1:0] ports);
    lock_req_t r;
    r.mode  = mode;
    r.ch    = CH_W'(ch);
    r.ports = ports;
    pending_reqs.push_back(r);
  endtask

  // Port masks lean on a few low ports so that conflicts, deep queues and
  // chains of promotions are common. Empty, full and fully random masks are
  // mixed in as well.
  function automatic logic [PMASK_W-1:0] pick_ports();
    logic [PMASK_W-1:0] m;
    int k;
    m = '0;
    k = $urandom_range(0, 19);
    if (k < 2) begin
      m = '0;
    end else if (k == 2) begin
      m = '1;
    end else if (k < 5) begin
      m = $urandom;
    end else if (k < 12) begin
      repeat ($urandom_range(1, 3)) m[$urandom_range(0, 5)] = 1'b1;
    end else begin
      repeat ($urandom_range(1, 3)) m[$urandom_range(0, N_PORTS - 1)] = 1'b1;
    end
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, then random gaps. A request
  // stays on the bus until the handshake takes it.
  // --------------------------------------------------------------------------
  logic      req_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  lock_req_t next_req;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !req_taken) begin
      // hold the current request
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (pending_reqs.size() != 0) begin
      next_req = pending_reqs.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= next_req.mode;
      in_tdata  <= {{(IN_TDATA_W - PMASK_W - CH_W){1'b0}}, next_req.ports, next_req.ch};
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result-side stall pattern. It moves in turn through these modes:
  // always ready, coin flip, mostly stalled, and long stall runs.
  // --------------------------------------------------------------------------
  int stall_cyc = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    case ((stall_cyc / 300) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          out_tready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 30);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted status
  // --------------------------------------------------------------------------
  lock_req_t    seen_req;
  lock_status_t want;

  always @(posedge clk) begin
    req_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_req.mode  = in_tuser;
        seen_req.ch    = in_tdata[CH_W-1:0];
        seen_req.ports = in_tdata[CH_W +: PMASK_W];
        expected_status.push_back(arbitrate_request(seen_req));
      end
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected status word", int'(out_tdata), 0);
        end else begin
          want = expected_status.pop_front();
          if (out_tdata[0] !== want.granted)
            report_mismatch("granted", int'(out_tdata[0]), int'(want.granted));
          if (out_tdata[2:1] !== want.cstate)
            report_mismatch("caller_state", int'(out_tdata[2:1]), int'(want.cstate));
          if (out_tdata[18:3] !== want.run_mask)
            report_mismatch("running_mask", int'(out_tdata[18:3]), int'(want.run_mask));
          if (out_tdata[23:19] !== want.wait_cnt)
            report_mismatch("waiting_count", int'(out_tdata[23:19]), int'(want.wait_cnt));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [N_CH-1:0] held;
    int ch;

    for (int c = 0; c < N_CH; c++) begin
      lk_state[c] = CST_IDLE;
      lk_ports[c] = '0;
    end
    lk_busy = '0;

    // directed requests
    add_req(MODE_LOCK,   0, 32'hFFFF_FFFF);  // runs, owns every port
    add_req(MODE_LOCK,   1, 32'h0000_0001);  // conflicts, so it waits
    add_req(MODE_LOCK,   2, 32'h0000_0000);  // no ports, runs at once
    add_req(MODE_LOCK,   1, 32'h0000_0002);  // repeat lock while waiting
    add_req(MODE_LOCK,   0, 32'h0000_0000);  // repeat lock while running
    add_req(MODE_UNLOCK, 3, 32'h1234_5678);  // unlock of an idle channel
    add_req(MODE_LOCK,   3, 32'h8000_0000);
    add_req(MODE_LOCK,  15, 32'h0001_0000);
    add_req(MODE_LOCK,   4, 32'h0000_0001);
    add_req(MODE_UNLOCK, 1, 32'h0);          // dequeue a waiter, nothing freed
    add_req(MODE_UNLOCK, 0, 32'h0);          // frees all: 3, 15, 4 promoted
    add_req(MODE_LOCK,   5, 32'h8000_0001);  // blocked by 3 and 4
    add_req(MODE_LOCK,   6, 32'h0000_0002);
    add_req(MODE_UNLOCK, 3, 32'h0);          // 5 still blocked by 4
    add_req(MODE_UNLOCK, 4, 32'h0);          // 5 promoted
    add_req(MODE_UNLOCK, 2, 32'h0);
    add_req(MODE_UNLOCK, 5, 32'h0);
    add_req(MODE_UNLOCK, 6, 32'h0);
    add_req(MODE_UNLOCK, 15, 32'h0);
    add_req(MODE_LOCK,   7, 32'hAAAA_AAAA);
    add_req(MODE_LOCK,   8, 32'h5555_5555);
    add_req(MODE_UNLOCK, 7, 32'h0);
    add_req(MODE_UNLOCK, 8, 32'h0);
    add_req(MODE_UNLOCK, 7, 32'hFFFF_FFFF);

    // Random requests. Whether a channel holds a lock (waiting or running)
    // can be followed exactly: a lock sets it and an unlock clears it.
    // Mostly well-formed: idle channels lock, holders unlock. A share of
    // repeat locks and unlocks of idle channels is mixed in as noise.
    held = '0;
    for (int n = 0; n < N_RANDOM; n++) begin
      ch = $urandom_range(0, N_CH - 1);
      if (!held[ch]) begin
        if ($urandom_range(0, 99) < 88) begin
          add_req(MODE_LOCK, ch, pick_ports());
          held[ch] = 1'b1;
        end else begin
          add_req(MODE_UNLOCK, ch, $urandom);
        end
      end else if ($urandom_range(0, 99) < 65) begin
        add_req(MODE_UNLOCK, ch, $urandom);
        held[ch] = 1'b0;
      end else begin
        add_req(MODE_LOCK, ch, pick_ports());
      end
    end

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: all requests taken, then every status word back, then settle
    while (pending_reqs.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (err_count == 0) begin
      $display("port_lock_fifo_arbiter_core: match");
    end else begin
      $display("port_lock_fifo_arbiter_core: mismatch");
    end
    $finish;
  end

  // hard stop: well above the slowest correct run
  initial begin
    #10_000_000;
    $display("port_lock_fifo_arbiter_core: mismatch");
    $finish;
  end

endmodule

### sim.f
hw/rtl/pla_pkg.sv
hw/rtl/pla_wait_queue.sv
hw/rtl/pla_port_store.sv
hw/rtl/port_lock_fifo_arbiter_core.sv
hw/rtl/pla_checker.sv
dv/tb_port_lock_fifo_arbiter_core.sv
